[rtl/rocp_pkg.sv]
// Shared types and constants of the reference-counted object cache policy core.
`default_nettype none

package rocp_pkg;

	localparam int CACHE_ENTRIES = 16;
	localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int ID_W = 48;
	localparam int CNT_W = 16;
	localparam int SLOT_W = 4;
	localparam int ACT_W = 3;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	localparam logic [ACT_W-1:0] ACT_LOOKUP = 3'd0;
	localparam logic [ACT_W-1:0] ACT_ALLOC = 3'd1;
	localparam logic [ACT_W-1:0] ACT_REF = 3'd2;
	localparam logic [ACT_W-1:0] ACT_UNREF = 3'd3;
	localparam logic [ACT_W-1:0] ACT_DIRTY = 3'd4;
	localparam logic [ACT_W-1:0] ACT_FREE = 3'd5;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic container;
		logic dirty;
		logic [CNT_W-1:0] refcount;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic found;
		logic [IDX_W-1:0] idx;
		entry_t entry;
	} cand_t;

	typedef struct packed {
		cand_t hit;
		cand_t empty;
		cand_t unref_plain;
		cand_t unref_any;
	} scan_t;

	typedef struct packed {
		logic hit;
		logic [SLOT_W-1:0] slot;
		logic cache_full;
		logic evicted_valid;
		logic [ID_W-1:0] evicted_id;
		logic writeback_needed;
		logic [CNT_W-1:0] ref_count;
	} result_t;

endpackage

`default_nettype wire

[rtl/rocp_ram.sv]
// Single-port-write, single-port-read synchronous RAM holding the slot records.
`default_nettype none

module rocp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[rtl/rocp_scan.sv]
// Candidate tracker that records hit and victim candidates while the slots stream past.
`default_nettype none

module rocp_scan (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       clear,
	input  wire logic                       step,
	input  wire logic                       lookup,
	input  wire logic [rocp_pkg::ID_W-1:0]  id,
	input  wire logic [rocp_pkg::IDX_W-1:0] idx,
	input  wire logic                       valid,
	input  wire rocp_pkg::entry_t           entry,
	output      rocp_pkg::scan_t            scan
);

	rocp_pkg::scan_t scan_q;
	logic hit_c;
	logic empty_c;
	logic plain_c;
	logic any_c;

	always_comb begin
		hit_c = step && lookup && valid && (entry.id == id) && !scan_q.hit.found;
		empty_c = step && !valid && !scan_q.empty.found;
		plain_c = step && valid && (entry.refcount == '0) && !entry.container
			&& !scan_q.unref_plain.found;
		any_c = step && valid && (entry.refcount == '0) && !scan_q.unref_any.found;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (clear) begin
			scan_q.hit.found <= 1'b0;
			scan_q.empty.found <= 1'b0;
			scan_q.unref_plain.found <= 1'b0;
			scan_q.unref_any.found <= 1'b0;
		end else begin
			if (hit_c) begin
				scan_q.hit.found <= 1'b1;
				scan_q.hit.idx <= idx;
				scan_q.hit.entry <= entry;
			end
			if (empty_c) begin
				scan_q.empty.found <= 1'b1;
				scan_q.empty.idx <= idx;
				scan_q.empty.entry <= entry;
			end
			if (plain_c) begin
				scan_q.unref_plain.found <= 1'b1;
				scan_q.unref_plain.idx <= idx;
				scan_q.unref_plain.entry <= entry;
			end
			if (any_c) begin
				scan_q.unref_any.found <= 1'b1;
				scan_q.unref_any.idx <= idx;
				scan_q.unref_any.entry <= entry;
			end
		end
	end

	assign scan = scan_q;

endmodule

`default_nettype wire

[rtl/refcounted_object_cache_policy_core.sv]
// Top level of the reference-counted object cache policy core.
//
// Requests enter on the in channel (in_valid, in_ready) with fields action,
// object_id, container_flag and slot_index; each request gives exactly one
// result on the out channel (out_valid, out_ready). One request is worked on
// at a time. A lookup or allocate reads all CACHE_ENTRIES slot records from
// the slot RAM, one per cycle, then writes the chosen slot back if there is
// one: the result is registered in ST_WB, moved to the output register in
// ST_PUSH, and the block then goes back to ST_IDLE for the next request.
// Ref, unref, mark dirty and free of a filled slot take one RAM read and one
// write; other requests skip the RAM and go straight to ST_PUSH.
// The output register lets a new request be taken while a result still
// waits; if the receiver stalls, a finished result is held inside until the
// output register frees up, and no further request is taken until then.
// Reset empties every slot at once through per-slot valid flags, so the
// block takes requests in the first cycle after reset.
`default_nettype none

module refcounted_object_cache_policy_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output      logic                          in_ready,
	input  wire logic [rocp_pkg::ACT_W-1:0]    action,
	input  wire logic [rocp_pkg::ID_W-1:0]     object_id,
	input  wire logic                          container_flag,
	input  wire logic [rocp_pkg::SLOT_W-1:0]   slot_index,
	output      logic                          out_valid,
	input  wire logic                          out_ready,
	output      logic                          hit,
	output      logic [rocp_pkg::SLOT_W-1:0]   slot,
	output      logic                          cache_full,
	output      logic                          evicted_valid,
	output      logic [rocp_pkg::ID_W-1:0]     evicted_id,
	output      logic                          writeback_needed,
	output      logic [rocp_pkg::CNT_W-1:0]    ref_count
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SCAN = 5'b00010,
		ST_SLOT = 5'b00100,
		ST_WB   = 5'b01000,
		ST_PUSH = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	logic [rocp_pkg::ACT_W-1:0] act_q;
	logic [rocp_pkg::ID_W-1:0] id_q;
	logic cont_q;
	logic [rocp_pkg::SLOT_W-1:0] sidx_q;
	logic [rocp_pkg::IDX_W-1:0] scan_q;
	logic [rocp_pkg::CACHE_ENTRIES-1:0] valid_q;

	rocp_pkg::result_t res_q;
	rocp_pkg::result_t res_d;
	logic res_load;
	rocp_pkg::result_t out_q;
	logic out_valid_q;

	logic accept;
	logic scan_act;
	logic in_range;
	logic [rocp_pkg::IDX_W-1:0] in_idx;
	logic [rocp_pkg::IDX_W-1:0] sidx_idx;
	logic [rocp_pkg::IDX_W-1:0] rd_addr;
	rocp_pkg::entry_t rd_entry;
	rocp_pkg::scan_t scan;
	logic scan_last;

	logic mem_we;
	logic [rocp_pkg::IDX_W-1:0] mem_waddr;
	rocp_pkg::entry_t mem_wdata;
	logic v_set;
	logic v_clr;
	logic [rocp_pkg::IDX_W-1:0] v_idx;
	rocp_pkg::cand_t victim;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign scan_act = (action == rocp_pkg::ACT_LOOKUP) || (action == rocp_pkg::ACT_ALLOC);
	assign in_range = (32'(slot_index) < rocp_pkg::CACHE_ENTRIES);
	assign in_idx = rocp_pkg::IDX_W'(slot_index);
	assign sidx_idx = rocp_pkg::IDX_W'(sidx_q);
	assign scan_last = (scan_q == rocp_pkg::IDX_W'(rocp_pkg::CACHE_ENTRIES - 1));

	always_comb begin
		if (state_q == ST_SCAN) begin
			rd_addr = scan_q + rocp_pkg::IDX_W'(1);
		end else if (scan_act) begin
			rd_addr = '0;
		end else begin
			rd_addr = in_idx;
		end
	end

	rocp_ram #(
		.WIDTH(rocp_pkg::ENTRY_W),
		.DEPTH(rocp_pkg::CACHE_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(rd_addr),
		.rdata(rd_entry)
	);

	rocp_scan u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.clear (accept),
		.step  (state_q == ST_SCAN),
		.lookup(act_q == rocp_pkg::ACT_LOOKUP),
		.id    (id_q),
		.idx   (scan_q),
		.valid (valid_q[scan_q]),
		.entry (rd_entry),
		.scan  (scan)
	);

	always_comb begin
		if (scan.empty.found) begin
			victim = scan.empty;
		end else if (scan.unref_plain.found) begin
			victim = scan.unref_plain;
		end else begin
			victim = scan.unref_any;
		end
	end

	always_comb begin
		state_d = state_q;
		res_d = '0;
		res_load = 1'b0;
		mem_we = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		v_set = 1'b0;
		v_clr = 1'b0;
		v_idx = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (action) inside
						rocp_pkg::ACT_LOOKUP, rocp_pkg::ACT_ALLOC: begin
							state_d = ST_SCAN;
						end
						rocp_pkg::ACT_REF, rocp_pkg::ACT_UNREF,
						rocp_pkg::ACT_DIRTY, rocp_pkg::ACT_FREE: begin
							if (in_range && valid_q[in_idx]) begin
								state_d = ST_SLOT;
							end else begin
								res_d.slot = slot_index;
								res_load = 1'b1;
								state_d = ST_PUSH;
							end
						end
						default: begin
							res_load = 1'b1;
							state_d = ST_PUSH;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_WB;
				end
			end
			ST_WB: begin
				res_load = 1'b1;
				state_d = ST_PUSH;
				if (scan.hit.found) begin
					mem_we = 1'b1;
					mem_waddr = scan.hit.idx;
					mem_wdata = scan.hit.entry;
					if (scan.hit.entry.refcount != rocp_pkg::CNT_MAX) begin
						mem_wdata.refcount = scan.hit.entry.refcount + rocp_pkg::CNT_ONE;
					end
					res_d.hit = 1'b1;
					res_d.slot = rocp_pkg::SLOT_W'(scan.hit.idx);
					res_d.ref_count = mem_wdata.refcount;
				end else if (victim.found) begin
					mem_we = 1'b1;
					mem_waddr = victim.idx;
					mem_wdata.id = id_q;
					mem_wdata.container = cont_q;
					mem_wdata.dirty = 1'b0;
					mem_wdata.refcount = rocp_pkg::CNT_ONE;
					v_set = 1'b1;
					v_idx = victim.idx;
					res_d.slot = rocp_pkg::SLOT_W'(victim.idx);
					res_d.ref_count = rocp_pkg::CNT_ONE;
					if (!scan.empty.found) begin
						res_d.evicted_valid = 1'b1;
						res_d.evicted_id = victim.entry.id;
						res_d.writeback_needed = victim.entry.dirty;
					end
				end else begin
					res_d.cache_full = 1'b1;
				end
			end
			ST_SLOT: begin
				res_load = 1'b1;
				state_d = ST_PUSH;
				mem_we = 1'b1;
				mem_waddr = sidx_idx;
				mem_wdata = rd_entry;
				case (act_q)
					rocp_pkg::ACT_REF: begin
						if (rd_entry.refcount != rocp_pkg::CNT_MAX) begin
							mem_wdata.refcount = rd_entry.refcount + rocp_pkg::CNT_ONE;
						end
					end
					rocp_pkg::ACT_UNREF: begin
						if (rd_entry.refcount != '0) begin
							mem_wdata.refcount = rd_entry.refcount - rocp_pkg::CNT_ONE;
						end
					end
					rocp_pkg::ACT_DIRTY: begin
						mem_wdata.dirty = 1'b1;
					end
					default: begin
						if (rd_entry.refcount <= rocp_pkg::CNT_ONE) begin
							mem_wdata.dirty = 1'b0;
							mem_wdata.refcount = '0;
							v_clr = 1'b1;
							v_idx = sidx_idx;
						end
					end
				endcase
				res_d.slot = sidx_q;
				res_d.ref_count = mem_wdata.refcount;
			end
			ST_PUSH: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			out_valid_q <= 1'b0;
			scan_q <= '0;
		end else begin
			state_q <= state_d;
			if (v_set) begin
				valid_q[v_idx] <= 1'b1;
			end
			if (v_clr) begin
				valid_q[v_idx] <= 1'b0;
			end
			if (accept) begin
				scan_q <= '0;
			end else if (state_q == ST_SCAN) begin
				scan_q <= scan_q + rocp_pkg::IDX_W'(1);
			end
			if (state_q == ST_PUSH && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action;
			id_q <= object_id;
			cont_q <= container_flag;
			sidx_q <= slot_index;
		end
		if (res_load) begin
			res_q <= res_d;
		end
		if (state_q == ST_PUSH && (!out_valid_q || out_ready)) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign hit = out_q.hit;
	assign slot = out_q.slot;
	assign cache_full = out_q.cache_full;
	assign evicted_valid = out_q.evicted_valid;
	assign evicted_id = out_q.evicted_id;
	assign writeback_needed = out_q.writeback_needed;
	assign ref_count = out_q.ref_count;

	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.cache_full |-> !out_q.evicted_valid && !out_q.hit
			&& out_q.ref_count == '0)
		else $error("Full result carries an eviction, a hit or a count.");

	a_wb_needs_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.writeback_needed |-> out_q.evicted_valid)
		else $error("Write-back flagged without an eviction.");

	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.hit |-> out_q.ref_count != '0)
		else $error("Hit reported with a zero count.");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_WB || state_q == ST_SLOT))
		else $error("Slot RAM written outside a write-back state.");

	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept && scan_act |=> state_q == ST_SCAN && scan_q == '0)
		else $error("Lookup or allocate did not start a scan at slot zero.");

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the reference-counted object cache policy core.
module tb_top;

	localparam logic [rocp_pkg::ACT_W-1:0] ACT_RSVD6 = 3'd6;
	localparam logic [rocp_pkg::ACT_W-1:0] ACT_RSVD7 = 3'd7;
	localparam int IDLE_LIMIT = 5000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int RANDOM_ITEMS = 380;
	localparam int ID_POOL_SIZE = 24;
	localparam int MAX_REPORTS = 10;
	localparam int DIR_ROWS = 18;
	localparam logic [rocp_pkg::ID_W-1:0] REFILL_ID = 48'h1;

	typedef struct {
		logic [rocp_pkg::ACT_W-1:0] act;
		logic [rocp_pkg::ID_W-1:0] id;
		logic cont;
		logic [rocp_pkg::SLOT_W-1:0] sidx;
		bit known;
		rocp_pkg::result_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [rocp_pkg::ACT_W-1:0] action = '0;
	logic [rocp_pkg::ID_W-1:0] object_id = '0;
	logic container_flag = 1'b0;
	logic [rocp_pkg::SLOT_W-1:0] slot_index = '0;
	logic out_ready = 1'b0;
	logic in_ready;
	logic out_valid;
	logic hit;
	logic [rocp_pkg::SLOT_W-1:0] slot;
	logic cache_full;
	logic evicted_valid;
	logic [rocp_pkg::ID_W-1:0] evicted_id;
	logic writeback_needed;
	logic [rocp_pkg::CNT_W-1:0] ref_count;

	logic slot_valid[rocp_pkg::CACHE_ENTRIES];
	logic [rocp_pkg::ID_W-1:0] slot_id[rocp_pkg::CACHE_ENTRIES];
	logic slot_container[rocp_pkg::CACHE_ENTRIES];
	logic slot_dirty[rocp_pkg::CACHE_ENTRIES];
	logic [rocp_pkg::CNT_W-1:0] slot_count[rocp_pkg::CACHE_ENTRIES];

	rocp_pkg::result_t pending_results[$];
	rocp_pkg::result_t last_prediction;
	int fail_count = 0;
	int quiet_cycles = 0;
	bit steady = 1'b0;
	bit hold_off_req = 1'b0;
	bit hold_off_done = 1'b0;

	refcounted_object_cache_policy_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.object_id(object_id),
		.container_flag(container_flag),
		.slot_index(slot_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hit(hit),
		.slot(slot),
		.cache_full(cache_full),
		.evicted_valid(evicted_valid),
		.evicted_id(evicted_id),
		.writeback_needed(writeback_needed),
		.ref_count(ref_count)
	);

	always #5 clk = ~clk;

	function automatic rocp_pkg::result_t known_result(input logic h,
			input logic [rocp_pkg::SLOT_W-1:0] s, input logic f, input logic ev,
			input logic [rocp_pkg::ID_W-1:0] eid, input logic wb,
			input logic [rocp_pkg::CNT_W-1:0] c);
		return {h, s, f, ev, eid, wb, c};
	endfunction

	function automatic logic [rocp_pkg::ID_W-1:0] random_id();
		return rocp_pkg::ID_W'({$urandom, $urandom});
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	function automatic rocp_pkg::result_t predict_cache_result(
			input logic [rocp_pkg::ACT_W-1:0] act, input logic [rocp_pkg::ID_W-1:0] id,
			input logic cont, input logic [rocp_pkg::SLOT_W-1:0] sidx);
		rocp_pkg::result_t r;
		int found;
		int victim;
		int k;
		r = '0;
		found = -1;
		victim = -1;
		if (act == rocp_pkg::ACT_LOOKUP || act == rocp_pkg::ACT_ALLOC) begin
			if (act == rocp_pkg::ACT_LOOKUP) begin
				for (k = 0; k < rocp_pkg::CACHE_ENTRIES; k++)
					if (found < 0 && slot_valid[k] && slot_id[k] == id)
						found = k;
			end
			if (found >= 0) begin
				if (slot_count[found] != rocp_pkg::CNT_MAX)
					slot_count[found] = slot_count[found] + rocp_pkg::CNT_ONE;
				r.hit = 1'b1;
				r.slot = rocp_pkg::SLOT_W'(found);
				r.ref_count = slot_count[found];
			end else begin
				for (k = 0; k < rocp_pkg::CACHE_ENTRIES; k++)
					if (victim < 0 && !slot_valid[k])
						victim = k;
				for (k = 0; k < rocp_pkg::CACHE_ENTRIES; k++)
					if (victim < 0 && slot_count[k] == '0 && !slot_container[k])
						victim = k;
				for (k = 0; k < rocp_pkg::CACHE_ENTRIES; k++)
					if (victim < 0 && slot_count[k] == '0)
						victim = k;
				if (victim < 0) begin
					r.cache_full = 1'b1;
				end else begin
					if (slot_valid[victim]) begin
						r.evicted_valid = 1'b1;
						r.evicted_id = slot_id[victim];
						r.writeback_needed = slot_dirty[victim];
					end
					slot_valid[victim] = 1'b1;
					slot_id[victim] = id;
					slot_container[victim] = cont;
					slot_dirty[victim] = 1'b0;
					slot_count[victim] = rocp_pkg::CNT_ONE;
					r.slot = rocp_pkg::SLOT_W'(victim);
					r.ref_count = rocp_pkg::CNT_ONE;
				end
			end
		end else if (act >= rocp_pkg::ACT_REF && act <= rocp_pkg::ACT_FREE) begin
			r.slot = sidx;
			if (int'(sidx) < rocp_pkg::CACHE_ENTRIES && slot_valid[sidx]) begin
				case (act)
				rocp_pkg::ACT_REF: begin
					if (slot_count[sidx] != rocp_pkg::CNT_MAX)
						slot_count[sidx] = slot_count[sidx] + rocp_pkg::CNT_ONE;
				end
				rocp_pkg::ACT_UNREF: begin
					if (slot_count[sidx] != '0)
						slot_count[sidx] = slot_count[sidx] - rocp_pkg::CNT_ONE;
				end
				rocp_pkg::ACT_DIRTY: begin
					slot_dirty[sidx] = 1'b1;
				end
				default: begin
					if (slot_count[sidx] <= rocp_pkg::CNT_ONE) begin
						slot_valid[sidx] = 1'b0;
						slot_dirty[sidx] = 1'b0;
						slot_count[sidx] = '0;
					end
				end
				endcase
				r.ref_count = slot_count[sidx];
			end
		end
		return r;
	endfunction

	task automatic offer_request(input logic [rocp_pkg::ACT_W-1:0] act,
			input logic [rocp_pkg::ID_W-1:0] id, input logic cont,
			input logic [rocp_pkg::SLOT_W-1:0] sidx, input bit use_known,
			input rocp_pkg::result_t known);
		int gap;
		in_valid <= 1'b1;
		action <= act;
		object_id <= id;
		container_flag <= cont;
		slot_index <= sidx;
		do @(posedge clk); while (in_ready !== 1'b1);
		last_prediction = predict_cache_result(act, id, cont, sidx);
		pending_results.push_back(use_known ? known : last_prediction);
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin : stimulus
		dir_row_t dir_rows[DIR_ROWS];
		logic [rocp_pkg::ID_W-1:0] id_pool[ID_POOL_SIZE];
		logic [rocp_pkg::ID_W-1:0] id;
		logic [rocp_pkg::ACT_W-1:0] act;
		int random_sent;
		int n;
		int kind;
		int pick;
		int len;
		for (n = 0; n < rocp_pkg::CACHE_ENTRIES; n++) begin
			slot_valid[n] = 1'b0;
			slot_id[n] = '0;
			slot_container[n] = 1'b0;
			slot_dirty[n] = 1'b0;
			slot_count[n] = '0;
		end
		for (n = 0; n < ID_POOL_SIZE; n++)
			id_pool[n] = random_id();

		dir_rows[0] = '{rocp_pkg::ACT_UNREF, '0, 1'b0, 4'd0, 1'b1,
			known_result(1'b0, 4'd0, 1'b0, 1'b0, '0, 1'b0, 16'd0)};
		dir_rows[1] = '{ACT_RSVD6, '1, 1'b1, 4'd15, 1'b1, '0};
		dir_rows[2] = '{ACT_RSVD7, 48'h5555_AAAA_5555, 1'b0, 4'd10, 1'b1, '0};
		dir_rows[3] = '{rocp_pkg::ACT_LOOKUP, '0, 1'b0, 4'd0, 1'b1,
			known_result(1'b0, 4'd0, 1'b0, 1'b0, '0, 1'b0, 16'd1)};
		dir_rows[4] = '{rocp_pkg::ACT_LOOKUP, '0, 1'b0, 4'd0, 1'b1,
			known_result(1'b1, 4'd0, 1'b0, 1'b0, '0, 1'b0, 16'd2)};
		dir_rows[5] = '{rocp_pkg::ACT_ALLOC, '1, 1'b1, 4'd0, 1'b1,
			known_result(1'b0, 4'd1, 1'b0, 1'b0, '0, 1'b0, 16'd1)};
		dir_rows[6] = '{rocp_pkg::ACT_ALLOC, '1, 1'b0, 4'd0, 1'b1,
			known_result(1'b0, 4'd2, 1'b0, 1'b0, '0, 1'b0, 16'd1)};
		dir_rows[7] = '{rocp_pkg::ACT_REF, '0, 1'b0, 4'd15, 1'b1,
			known_result(1'b0, 4'd15, 1'b0, 1'b0, '0, 1'b0, 16'd0)};
		dir_rows[8] = '{rocp_pkg::ACT_FREE, '0, 1'b0, 4'd0, 1'b1,
			known_result(1'b0, 4'd0, 1'b0, 1'b0, '0, 1'b0, 16'd2)};
		dir_rows[9] = '{rocp_pkg::ACT_UNREF, '0, 1'b0, 4'd0, 1'b0, '0};
		dir_rows[10] = '{rocp_pkg::ACT_UNREF, '0, 1'b0, 4'd0, 1'b0, '0};
		dir_rows[11] = '{rocp_pkg::ACT_UNREF, '0, 1'b0, 4'd0, 1'b1,
			known_result(1'b0, 4'd0, 1'b0, 1'b0, '0, 1'b0, 16'd0)};
		dir_rows[12] = '{rocp_pkg::ACT_DIRTY, '0, 1'b0, 4'd0, 1'b0, '0};
		dir_rows[13] = '{rocp_pkg::ACT_DIRTY, '0, 1'b0, 4'd14, 1'b1,
			known_result(1'b0, 4'd14, 1'b0, 1'b0, '0, 1'b0, 16'd0)};
		dir_rows[14] = '{rocp_pkg::ACT_FREE, '0, 1'b0, 4'd2, 1'b1,
			known_result(1'b0, 4'd2, 1'b0, 1'b0, '0, 1'b0, 16'd0)};
		dir_rows[15] = '{rocp_pkg::ACT_FREE, '0, 1'b0, 4'd13, 1'b0, '0};
		dir_rows[16] = '{rocp_pkg::ACT_UNREF, '1, 1'b0, 4'd1, 1'b0, '0};
		dir_rows[17] = '{rocp_pkg::ACT_ALLOC, REFILL_ID, 1'b0, 4'd0, 1'b0, '0};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < DIR_ROWS; n++)
			offer_request(dir_rows[n].act, dir_rows[n].id, dir_rows[n].cont,
				dir_rows[n].sidx, dir_rows[n].known, dir_rows[n].want);

		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			if (random_sent >= RANDOM_ITEMS / 3)
				hold_off_req = 1'b1;
			steady = ($urandom_range(0, 4) == 0);
			kind = $urandom_range(0, 9);
			if (kind < 3) begin
				last_prediction = '0;
				for (n = 0; n < 24 && !last_prediction.cache_full; n++) begin
					act = ($urandom_range(0, 3) == 0) ? rocp_pkg::ACT_LOOKUP
						: rocp_pkg::ACT_ALLOC;
					id = $urandom_range(0, 1) ? id_pool[$urandom_range(0, ID_POOL_SIZE - 1)]
						: random_id();
					offer_request(act, id, 1'($urandom_range(0, 1)),
						rocp_pkg::SLOT_W'($urandom), 1'b0, '0);
					random_sent++;
				end
			end else if (kind < 6) begin
				len = $urandom_range(5, 20);
				repeat (len) begin
					pick = $urandom_range(0, 99);
					act = (pick < 50) ? rocp_pkg::ACT_UNREF :
						(pick < 70) ? rocp_pkg::ACT_DIRTY :
						(pick < 90) ? rocp_pkg::ACT_FREE : rocp_pkg::ACT_REF;
					offer_request(act, random_id(), 1'($urandom_range(0, 1)),
						rocp_pkg::SLOT_W'($urandom), 1'b0, '0);
					random_sent++;
				end
			end else begin
				len = $urandom_range(10, 30);
				repeat (len) begin
					pick = $urandom_range(0, 99);
					id = id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
					if (pick < 30) begin
						act = rocp_pkg::ACT_LOOKUP;
					end else if (pick < 40) begin
						act = rocp_pkg::ACT_ALLOC;
					end else if (pick < 55) begin
						act = rocp_pkg::ACT_REF;
					end else if (pick < 70) begin
						act = rocp_pkg::ACT_UNREF;
					end else if (pick < 80) begin
						act = rocp_pkg::ACT_DIRTY;
					end else if (pick < 92) begin
						act = rocp_pkg::ACT_FREE;
					end else if (pick < 96) begin
						act = rocp_pkg::ACT_LOOKUP;
						id = random_id();
					end else begin
						act = $urandom_range(0, 1) ? ACT_RSVD6 : ACT_RSVD7;
						id = random_id();
					end
					offer_request(act, id, 1'($urandom_range(0, 1)),
						rocp_pkg::SLOT_W'($urandom), 1'b0, '0);
					if (act <= rocp_pkg::ACT_FREE)
						random_sent++;
				end
				if ($urandom_range(0, 1))
					id_pool[$urandom_range(0, ID_POOL_SIZE - 1)] = random_id();
			end
		end
		steady = 1'b0;
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4 * rocp_pkg::CACHE_ENTRIES) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin : result_sink
		int run;
		int stall;
		@(posedge clk);
		forever begin
			if (hold_off_req && !hold_off_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_done = 1'b1;
			end else begin
				stall = steady ? 0 : pick_gap();
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				out_ready <= 1'b1;
				run = $urandom_range(1, 24);
				repeat (run) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : result_check
		rocp_pkg::result_t got;
		rocp_pkg::result_t want;
		got = {hit, slot, cache_full, evicted_valid, evicted_id, writeback_needed, ref_count};
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("unexpected result with no request pending: %p", got);
			end else begin
				want = pending_results.pop_front();
				if (got.hit !== want.hit || got.slot !== want.slot
						|| got.cache_full !== want.cache_full
						|| got.evicted_valid !== want.evicted_valid
						|| got.evicted_id !== want.evicted_id
						|| got.writeback_needed !== want.writeback_needed
						|| got.ref_count !== want.ref_count) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS) begin
						$write("mismatch at %0t: expected hit=%0d slot=%0d full=%0d",
							$realtime, want.hit, want.slot, want.cache_full);
						$display(" evict=%0d id=%h wb=%0d count=%0d", want.evicted_valid,
							want.evicted_id, want.writeback_needed, want.ref_count);
						$write("             actual   hit=%0d slot=%0d full=%0d",
							got.hit, got.slot, got.cache_full);
						$display(" evict=%0d id=%h wb=%0d count=%0d", got.evicted_valid,
							got.evicted_id, got.writeback_needed, got.ref_count);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

endmodule

[sim.f]
rtl/rocp_pkg.sv
rtl/rocp_ram.sv
rtl/rocp_scan.sv
rtl/refcounted_object_cache_policy_core.sv
sim/tb_top.sv
